/* src/rpdm_pkg.sv */
package rpdm_pkg;

  // Field widths of the pixel, table and register words.
  localparam int RAW_W    = 16;
  localparam int IDX_W    = 8;
  localparam int LEVEL_W  = 8;
  localparam int LIMIT_W  = 16;
  localparam int OFFSET_W = 25;
  localparam int GAIN_W   = 32;
  localparam int CFG_W    = 32;

  // Datapath widths: Q8 difference, Q24 product, Q24 biased value.
  localparam int DIFF_W = RAW_W + 8 + 2;
  localparam int PROD_W = DIFF_W + GAIN_W;
  localparam int VAL_W  = PROD_W + 1;
  localparam int FRAC_W = 24;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t CFG_GOOD_LIMIT   = 2'd0;
  localparam cfg_index_t CFG_BLACK_OFFSET = 2'd1;
  localparam cfg_index_t CFG_GAIN         = 2'd2;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_TABLE = 1'b1
  } req_t;

endpackage

/* src/raw_pixel_display_mapper.sv */
// Raw pixel to display mapper. Each input word is either a pixel to map or a
// write of one gamma table entry (req_type). A pixel above good_limit comes out
// pure red; otherwise the block forms 128 + gain_q16 * (raw - black_offset_q8)
// exactly in Q24, clamps it to 0..255, rounds half up to an 8-bit index and
// emits the gamma table entry at that index as gray on red, green and blue.
// Table entries must be written before any pixel reads them. Throughput is one
// word per clock unless the output stalls; a pixel passes stages 1 to 3 into
// the output register, and a table write occupies one pipeline slot and gives
// no result. The four stages are: offset subtract and limit compare, one 26x32
// signed multiply, bias add with clamp and rounding, then the table read into
// the output register. Table writes and pixel reads hit the table in the same
// stage, so every pixel sees exactly the writes accepted before it. There is no
// clearing pass after reset. Offset and limit act on words accepted after a
// write, gain on words in stage 1 too; write them only while the block is idle.
module raw_pixel_display_mapper #(
  parameter int RAW_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  rpdm_pkg::cfg_index_t       cfg_index,
  input  logic [rpdm_pkg::CFG_W-1:0] cfg_data,
  // Input words
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       req_type,
  input  logic [rpdm_pkg::RAW_W-1:0] raw_pixel,
  input  logic [rpdm_pkg::IDX_W-1:0] table_index,
  input  logic [rpdm_pkg::LEVEL_W-1:0] table_value,
  // Result words
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rpdm_pkg::LEVEL_W-1:0] red,
  output logic [rpdm_pkg::LEVEL_W-1:0] green,
  output logic [rpdm_pkg::LEVEL_W-1:0] blue
);
  import rpdm_pkg::*;

  // Raw bits above RAW_BITS are ignored.
  localparam logic [RAW_W-1:0] RAW_MASK =
    (RAW_BITS >= RAW_W) ? {RAW_W{1'b1}} : RAW_W'((64'd1 << RAW_BITS) - 64'd1);

  // 128 and 255 in Q24.
  localparam logic signed [VAL_W-1:0] MID_Q24 =
    {{(VAL_W-FRAC_W-8){1'b0}}, 8'd128, {FRAC_W{1'b0}}};
  localparam logic signed [VAL_W-1:0] TOP_Q24 =
    {{(VAL_W-FRAC_W-8){1'b0}}, 8'd255, {FRAC_W{1'b0}}};

  // Configuration registers
  logic [LIMIT_W-1:0]         good_limit;
  logic signed [OFFSET_W-1:0] black_offset_q8;
  logic signed [GAIN_W-1:0]   gain_q16;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      good_limit      <= {LIMIT_W{1'b1}};
      black_offset_q8 <= '0;
      gain_q16        <= GAIN_W'(32'sd65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GOOD_LIMIT:   good_limit      <= cfg_data[LIMIT_W-1:0];
        CFG_BLACK_OFFSET: black_offset_q8 <= cfg_data[OFFSET_W-1:0];
        CFG_GAIN:         gain_q16        <= cfg_data[GAIN_W-1:0];
        default: ;  // unknown register: drop the write
      endcase
    end
  end

  // Pipeline valid bits and per-stage advance. A stage moves when it is empty
  // or the stage after it moves.
  logic s1_valid, s2_valid, s3_valid;
  logic adv1, adv2, adv3, adv_o;

  assign adv_o    = !out_valid || out_ready;
  assign adv3     = !s3_valid || adv_o;
  assign adv2     = !s2_valid || adv3;
  assign adv1     = !s1_valid || adv2;
  assign in_ready = adv1;

  // Stage 1: subtract the black offset (Q8) and compare against the limit.
  logic [RAW_W-1:0]         raw_m;
  logic signed [DIFF_W-1:0] diff_next;
  logic                     over_next;

  logic                     s1_write, s1_over;
  logic signed [DIFF_W-1:0] s1_diff;
  logic [IDX_W-1:0]         s1_index;
  logic [LEVEL_W-1:0]       s1_value;

  assign raw_m     = raw_pixel & RAW_MASK;
  assign diff_next = $signed({2'b00, raw_m, 8'h00}) - DIFF_W'(black_offset_q8);
  assign over_next = raw_m > good_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= in_valid;
    end
    if (adv1 && in_valid) begin
      s1_write <= (req_t'(req_type) == REQ_TABLE);
      s1_over  <= over_next;
      s1_diff  <= diff_next;
      s1_index <= table_index;
      s1_value <= table_value;
    end
  end

  // Stage 2: multiply by the gain, Q8 x Q16 -> Q24.
  logic signed [PROD_W-1:0] prod_next;

  logic                     s2_write, s2_over;
  logic signed [PROD_W-1:0] s2_prod;
  logic [IDX_W-1:0]         s2_index;
  logic [LEVEL_W-1:0]       s2_value;

  assign prod_next = PROD_W'(s1_diff) * PROD_W'(gain_q16);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
    if (adv2 && s1_valid) begin
      s2_write <= s1_write;
      s2_over  <= s1_over;
      s2_prod  <= prod_next;
      s2_index <= s1_index;
      s2_value <= s1_value;
    end
  end

  // Stage 3: add the mid-level bias, clamp to 0..255 and round half up.
  // Inside the clamp range the rounded index cannot pass 255.
  logic signed [VAL_W-1:0] v_q24;
  logic [IDX_W-1:0]        idx_next;

  logic                    s3_write, s3_over;
  logic [IDX_W-1:0]        s3_idx;
  logic [LEVEL_W-1:0]      s3_value;

  assign v_q24 = VAL_W'(s2_prod) + MID_Q24;

  always_comb begin
    if (v_q24[VAL_W-1]) begin
      idx_next = '0;
    end else if (v_q24 > TOP_Q24) begin
      idx_next = {IDX_W{1'b1}};
    end else begin
      idx_next = v_q24[FRAC_W+IDX_W-1:FRAC_W] + IDX_W'(v_q24[FRAC_W-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv3) begin
      s3_valid <= s2_valid;
    end
    if (adv3 && s2_valid) begin
      s3_write <= s2_write;
      s3_over  <= s2_over;
      // A table write carries its entry address in the index slot.
      s3_idx   <= s2_write ? s2_index : idx_next;
      s3_value <= s2_value;
    end
  end

  // Stage 4: gamma table. Writes and reads share this stage to keep order.
  logic [LEVEL_W-1:0] gamma_mem [2**IDX_W];
  logic [LEVEL_W-1:0] out_level;
  logic               out_over;

  always_ff @(posedge clk) begin
    if (adv_o && s3_valid) begin
      if (s3_write) begin
        gamma_mem[s3_idx] <= s3_value;
      end else begin
        out_level <= gamma_mem[s3_idx];
        out_over  <= s3_over;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_o) begin
      // Table writes leave a bubble: no result word.
      out_valid <= s3_valid && !s3_write;
    end
  end

  assign red   = out_over ? {LEVEL_W{1'b1}} : out_level;
  assign green = out_over ? '0 : out_level;
  assign blue  = out_over ? '0 : out_level;

`ifndef SYNTH
  // A table write leaving stage 3 never turns into a result word.
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_write && adv_o) |=> !out_valid)
    else $error("table write produced a result word");

  // An empty output register lets the whole pipe move, so input is open.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // A negative biased value clamps to index zero.
  a_clamp_low: assert property (@(posedge clk) disable iff (rst)
    (adv3 && s2_valid && !s2_write && v_q24[VAL_W-1]) |=> (s3_idx == '0))
    else $error("negative value not clamped to zero");

  // A pixel over the limit in stage 3 reaches the output flagged as over.
  a_over_flag: assert property (@(posedge clk) disable iff (rst)
    (adv_o && s3_valid && !s3_write && s3_over) |=> (out_valid && out_over))
    else $error("over-limit pixel lost its flag");
`endif

endmodule

/* tb/tb_top.sv */
module tb_top;
  import rpdm_pkg::*;

  // Register index that maps to nothing; the block must ignore writes to it.
  localparam cfg_index_t CFG_UNUSED = 2'd3;

  // Q24 landmarks of the biased value before the clamp.
  localparam longint ONE_Q24  = longint'(1) << FRAC_W;
  localparam longint MID_Q24  = 128 * ONE_Q24;
  localparam longint TOP_Q24  = 255 * ONE_Q24;
  localparam longint HALF_Q24 = ONE_Q24 / 2;

  // Pipeline is four deep; a table write leaves no result behind, so give the
  // block a few spare cycles beyond that before touching a register.
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 16;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } rgb_t;

  // Block inputs, all known from time zero.
  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_valid   = 1'b0;
  cfg_index_t           cfg_index   = CFG_GOOD_LIMIT;
  logic [CFG_W-1:0]     cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic                 req_type    = REQ_PIXEL;
  logic [RAW_W-1:0]     raw_pixel   = '0;
  logic [IDX_W-1:0]     table_index = '0;
  logic [LEVEL_W-1:0]   table_value = '0;
  logic                 out_ready   = 1'b0;

  // Block outputs.
  logic                 cfg_ready;
  logic                 in_ready;
  logic                 out_valid;
  logic [LEVEL_W-1:0]   red;
  logic [LEVEL_W-1:0]   green;
  logic [LEVEL_W-1:0]   blue;

  // Our own copy of the block state: gamma table and the three registers.
  logic [LEVEL_W-1:0]   gamma_levels [256];
  logic [LIMIT_W-1:0]   limit_q;
  longint               offset_q8;
  longint               gain_q16;

  rgb_t                 rgb_queue [$];
  int                   mismatch_count = 0;
  int                   quiet_cycles   = 0;
  int                   out_hold       = 0;
  bit                   no_idle        = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  raw_pixel_display_mapper u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .raw_pixel   (raw_pixel),
    .table_index (table_index),
    .table_value (table_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

  // Expected display triple for one pixel under the current registers and table.
  // Over the limit gives pure red; otherwise bias, scale, clamp, round half up.
  function automatic rgb_t map_pixel(input logic [RAW_W-1:0] raw);
    longint             lin;
    int unsigned        slot;
    logic [LEVEL_W-1:0] lvl;
    if (raw > limit_q) return '{red: '1, green: '0, blue: '0};
    lin = MID_Q24 + ((longint'(raw) <<< 8) - offset_q8) * gain_q16;
    if (lin < 0) lin = 0;
    else if (lin > TOP_Q24) lin = TOP_Q24;
    slot = int'((lin + HALF_Q24) >>> FRAC_W);
    lvl = gamma_levels[slot];
    return '{red: lvl, green: lvl, blue: lvl};
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Monitor: check the result word first, then take in register and input
  // words seen at this edge. Doing all of it in one process keeps the order
  // of push and pop fixed within a time step.
  always @(posedge clk) begin : monitor
    rgb_t want;
    if (rst) begin
      limit_q   = '1;
      offset_q8 = 0;
      gain_q16  = 65536;
    end else begin
      if (out_valid && out_ready) begin
        if (rgb_queue.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d/%0d with nothing pending",
                                    red, green, blue));
        end else begin
          want = rgb_queue.pop_front();
          if (red !== want.red)
            report_mismatch($sformatf("red got %0d want %0d", red, want.red));
          if (green !== want.green)
            report_mismatch($sformatf("green got %0d want %0d", green, want.green));
          if (blue !== want.blue)
            report_mismatch($sformatf("blue got %0d want %0d", blue, want.blue));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GOOD_LIMIT:   limit_q   = cfg_data[LIMIT_W-1:0];
          CFG_BLACK_OFFSET: offset_q8 = longint'($signed(cfg_data[OFFSET_W-1:0]));
          CFG_GAIN:         gain_q16  = longint'($signed(cfg_data[GAIN_W-1:0]));
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (req_type == REQ_TABLE) gamma_levels[table_index] = table_value;
        else rgb_queue.push_back(map_pixel(raw_pixel));
      end
    end
  end

  // Drop out_ready now and then for a few cycles; hold it high while no_idle.
  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_hold  <= out_hold - 1;
      out_ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 7) begin
      out_hold  <= $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: end the run when no word of any kind moves for too long.
  // A missing result also lands here, since the drain below never finishes.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (cfg_valid && cfg_ready) ||
        (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one input word and hold it until accepted. An idle gap, when
  // drawn, goes before the word so valid is never dropped and raised at once.
  task automatic send_word(input req_t kind, input logic [RAW_W-1:0] raw,
                           input logic [IDX_W-1:0] idx,
                           input logic [LEVEL_W-1:0] lvl);
    if (!no_idle && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= kind;
    raw_pixel   <= raw;
    table_index <= idx;
    table_value <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Table fields of a pixel word are don't-care; fill them with noise.
  task automatic send_pixel(input logic [RAW_W-1:0] raw);
    send_word(REQ_PIXEL, raw, IDX_W'($urandom), LEVEL_W'($urandom));
  endtask

  // Raw field of a table write is don't-care; fill it with noise.
  task automatic send_entry(input logic [IDX_W-1:0] idx, input logic [LEVEL_W-1:0] lvl);
    send_word(REQ_TABLE, RAW_W'($urandom), idx, lvl);
  endtask

  task automatic write_register(input cfg_index_t idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop feeding, let every pending result come out, then let the pipeline
  // run dry of table writes too. The first edge makes sure the monitor has
  // queued the last accepted pixel before the queue is looked at.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rgb_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Load every entry so no pixel can ever read an unwritten one; pin the two
  // end entries to the level extremes.
  task automatic test_table_load();
    for (int i = 0; i < 256; i++) begin
      if (i == 0) send_entry(IDX_W'(i), '1);
      else if (i == 255) send_entry(IDX_W'(i), '0);
      else send_entry(IDX_W'(i), LEVEL_W'($urandom));
    end
  endtask

  // Reset registers: unit gain, zero offset, full limit. 127 lands exactly on
  // the top of the clamp, 126 just under it.
  task automatic test_reset_defaults();
    send_pixel('0);
    send_pixel(16'd126);
    send_pixel(16'd127);
    send_pixel('1);
  endtask

  // Pixels at and just above the good-data limit, including a limit of zero.
  // Upper data bits are noise and must be masked off.
  task automatic test_good_limit();
    wait_idle();
    write_register(CFG_GOOD_LIMIT, {16'($urandom), 16'd1000});
    send_pixel(16'd1000);
    send_pixel(16'd1001);
    wait_idle();
    write_register(CFG_GOOD_LIMIT, {16'($urandom), 16'd0});
    send_pixel('0);
    send_pixel(16'd1);
    send_pixel('1);
    wait_idle();
    write_register(CFG_GOOD_LIMIT, {16'($urandom), 16'hFFFF});
  endtask

  // Offset and gain extremes, zero gain, negative gain, and halves that must
  // round up on both sides of mid-scale.
  task automatic test_offset_gain();
    wait_idle();
    write_register(CFG_BLACK_OFFSET, {7'($urandom), 25'd16776960});
    send_pixel('1);
    send_pixel('0);
    wait_idle();
    write_register(CFG_BLACK_OFFSET, {7'($urandom), 25'h1FFFF00});
    write_register(CFG_GAIN, 32'h7FFF_FFFF);
    send_pixel('0);
    wait_idle();
    write_register(CFG_GAIN, 32'h8000_0000);
    send_pixel('1);
    wait_idle();
    write_register(CFG_BLACK_OFFSET, {7'($urandom), 25'd0});
    write_register(CFG_GAIN, 32'h0000_0000);
    send_pixel(RAW_W'($urandom));
    wait_idle();
    write_register(CFG_GAIN, 32'h0000_8000);
    send_pixel(16'd1);
    send_pixel(16'd3);
    wait_idle();
    write_register(CFG_GAIN, 32'hFFFF_8000);
    send_pixel(16'd1);
  endtask

  task automatic test_unused_register();
    wait_idle();
    write_register(CFG_UNUSED, $urandom);
    send_pixel(RAW_W'($urandom));
    send_pixel(RAW_W'($urandom));
  endtask

  // Random phases: fresh registers each phase, then mostly pixels aimed at the
  // interesting region around the offset, the limit and the raw extremes,
  // mixed with table rewrites. Phases four to six run with no idling at all.
  task automatic test_random_traffic(input int phases, input int words);
    logic [LIMIT_W-1:0]  lim;
    logic [OFFSET_W-1:0] off;
    logic [GAIN_W-1:0]   gn;
    logic [RAW_W-1:0]    raw;
    int                  center;
    for (int p = 0; p < phases; p++) begin
      wait_idle();
      no_idle <= (p >= 4 && p < 7);
      case ($urandom_range(0, 7))
        0:       lim = '0;
        1, 2, 3: lim = '1;
        default: lim = LIMIT_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       off = 25'h1FFFF00;
        1:       off = 25'd16776960;
        2:       off = OFFSET_W'($urandom_range(0, 16776960));
        default: off = OFFSET_W'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0:       gn = 32'h7FFF_FFFF;
        1:       gn = 32'h8000_0000;
        2:       gn = $urandom;
        3, 4, 5: gn = $urandom_range(1, 1 << 12);
        default: gn = $urandom_range(0, 1 << 20);
      endcase
      if ($urandom_range(0, 1)) gn = -gn;
      write_register(CFG_GOOD_LIMIT, {16'($urandom), lim});
      write_register(CFG_BLACK_OFFSET, {7'($urandom), off});
      write_register(CFG_GAIN, gn);
      if ($urandom_range(0, 3) == 0) write_register(CFG_UNUSED, $urandom);
      // Aim near the raw value that the offset maps to mid-scale.
      center = int'($signed(off)) / 256;
      if (center < 0) center = 0;
      if (center > 65535) center = 65535;
      for (int w = 0; w < words; w++) begin
        if ($urandom_range(0, 99) < 15) begin
          send_entry(IDX_W'($urandom), LEVEL_W'($urandom));
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: raw = RAW_W'($urandom);
            5, 6, 7:       raw = RAW_W'(center + int'($urandom_range(0, 511)) - 256);
            8:             raw = lim + RAW_W'($urandom_range(0, 1));
            default:       raw = $urandom_range(0, 1) ? '0 : '1;
          endcase
          send_pixel(raw);
        end
      end
    end
    no_idle <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_table_load();
    test_reset_defaults();
    test_good_limit();
    test_offset_gain();
    test_unused_register();
    test_random_traffic(12, 120);
    // Drain, then watch a while longer for stray results.
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
